// ===== hw/rtl/sbfp_pkg.sv =====
`timescale 1ns / 1ps

package sbfp_pkg;

   // Default sizing
   localparam int MAX_SAMPLES_DEFAULT       = 64;
   localparam int SAMPLES_PER_FRAME_DEFAULT = 12;

   // Fixed field widths
   localparam int SAMPLE_W = 24;
   localparam int GSIZE_W  = 7;
   localparam int BYTE_W   = 8;

   // Command codes carried on tuser
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   // Frame framing bytes
   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h3A;
   localparam logic [BYTE_W-1:0] TYPE_BYTE = 8'h0C;
   localparam logic [BYTE_W-1:0] SUB_BYTE  = 8'h01;
   localparam logic [BYTE_W-1:0] END_BYTE  = 8'h7E;

   // Position of a byte inside the header or inside a sample
   localparam logic [2:0] HDR_SYNC  = 3'd0;
   localparam logic [2:0] HDR_TYPE  = 3'd1;
   localparam logic [2:0] HDR_SUB   = 3'd2;
   localparam logic [2:0] HDR_LEN   = 3'd3;
   localparam logic [2:0] HDR_COUNT = 3'd4;
   localparam logic [2:0] SMP_HI    = 3'd0;
   localparam logic [2:0] SMP_MID   = 3'd1;
   localparam logic [2:0] SMP_LO    = 3'd2;

   // Frame sequencer states
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_HEAD  = 6'b000010,
      ST_FETCH = 6'b000100,
      ST_DATA  = 6'b001000,
      ST_SUM   = 6'b010000,
      ST_END   = 6'b100000
   } seq_state_type;

endpackage

// ===== hw/rtl/sbfp_sample_mem.sv =====
`timescale 1ns / 1ps

module sbfp_sample_mem #(
   parameter int DEPTH = sbfp_pkg::MAX_SAMPLES_DEFAULT,
   parameter int WIDTH = sbfp_pkg::SAMPLE_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Store one sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sample_buffer_frame_packer_top.sv =====
`timescale 1ns / 1ps

// Buffers 3-byte samples that arrive in groups and packs them into framed byte
// streams. An append beat (tuser = 0) carries one sample; a group is dropped
// whole when the stored count plus its size would reach MAX_SAMPLES. A flush
// beat (tuser = 1) sends the next frame of up to SAMPLES_PER_FRAME samples:
// sync, type, subtype, length, count, the sample bytes, an 8-bit checksum and
// the end byte, one byte at a time on rsp, with tlast on the end byte. While a
// frame goes out req_tready stays low: five header bytes, then a sample-memory
// read state plus three byte states per sample, then checksum and end byte;
// the block has a single byte lane and one read port on the sample memory. A
// flush with nothing pending emits nothing and empties the buffer; once all
// samples have gone out the buffer is empty again.
module sample_buffer_frame_packer_top #(
   parameter int MAX_SAMPLES       = sbfp_pkg::MAX_SAMPLES_DEFAULT,
   parameter int SAMPLES_PER_FRAME = sbfp_pkg::SAMPLES_PER_FRAME_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // sample[23:0], group_size[30:24], group_first[31]
   input  logic        req_tuser,  // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // frame_byte[7:0]
   output logic        rsp_tlast
);

   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int AW   = $clog2(MAX_SAMPLES);
   localparam int NW   = $clog2(SAMPLES_PER_FRAME + 1);
   localparam int GW   = (CW > sbfp_pkg::GSIZE_W ? CW : sbfp_pkg::GSIZE_W) + 1;
   localparam int CMPW = (CW > NW) ? CW : NW;

   // Input fields
   logic                             cmd;
   logic [sbfp_pkg::SAMPLE_W-1:0]    sample;
   logic [sbfp_pkg::GSIZE_W-1:0]     group_size;
   logic                             group_first;

   assign cmd         = req_tuser;
   assign sample      = req_tdata[23:0];
   assign group_size  = req_tdata[30:24];
   assign group_first = req_tdata[31];

   // State
   sbfp_pkg::seq_state_type          state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    rp_ff, rp_in;
   logic                             dropping_ff, dropping_in;
   logic [NW-1:0]                    n_ff, n_in;
   logic [NW-1:0]                    sidx_ff, sidx_in;
   logic [2:0]                       bidx_ff, bidx_in;
   logic [AW-1:0]                    addr_ff, addr_in;
   logic [sbfp_pkg::BYTE_W-1:0]      sum_ff, sum_in;
   logic                             out_valid_ff, out_valid_in;
   logic [sbfp_pkg::BYTE_W-1:0]      out_byte_ff, out_byte_in;
   logic                             out_last_ff, out_last_in;

   logic                             accept;
   logic                             drop_now;
   logic                             keep;
   logic [GW-1:0]                    fill_sum;
   logic [CW-1:0]                    remaining;
   logic [CW-1:0]                    rp_next;
   logic [sbfp_pkg::BYTE_W-1:0]      len_byte;
   logic                             emit_valid;
   logic                             fire;
   logic [sbfp_pkg::BYTE_W-1:0]      emit_byte;
   logic                             emit_last;
   logic                             emit_sums;
   logic                             mem_wr_en;
   logic                             mem_rd_en;
   logic [sbfp_pkg::SAMPLE_W-1:0]    mem_rd_data;

   assign req_tready = (state_ff == sbfp_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Capacity check on a group start; later samples follow the last decision
   assign fill_sum  = GW'(count_ff) + GW'(group_size);
   assign drop_now  = group_first ? (fill_sum >= GW'(MAX_SAMPLES)) : dropping_ff;
   assign keep      = !drop_now && (count_ff < CW'(MAX_SAMPLES - 1));
   assign mem_wr_en = accept && (cmd == sbfp_pkg::CMD_APPEND) && keep;

   // Frame sizing
   assign remaining = count_ff - rp_ff;
   assign rp_next   = rp_ff + CW'(n_ff);
   assign len_byte  = 8'({n_ff, 1'b0}) + 8'(n_ff) + 8'd1;

   // Byte to send in the current state
   always_comb begin
      emit_valid = 1'b0;
      emit_byte  = sbfp_pkg::END_BYTE;
      emit_last  = 1'b0;
      emit_sums  = 1'b0;
      case (state_ff)
         sbfp_pkg::ST_HEAD: begin
            emit_valid = 1'b1;
            emit_sums  = (bidx_ff != sbfp_pkg::HDR_SYNC);
            case (bidx_ff)
               sbfp_pkg::HDR_SYNC:  emit_byte = sbfp_pkg::SYNC_BYTE;
               sbfp_pkg::HDR_TYPE:  emit_byte = sbfp_pkg::TYPE_BYTE;
               sbfp_pkg::HDR_SUB:   emit_byte = sbfp_pkg::SUB_BYTE;
               sbfp_pkg::HDR_LEN:   emit_byte = len_byte;
               sbfp_pkg::HDR_COUNT: emit_byte = 8'(n_ff);
               default:             emit_byte = sbfp_pkg::SYNC_BYTE;
            endcase
         end
         sbfp_pkg::ST_DATA: begin
            emit_valid = 1'b1;
            emit_sums  = 1'b1;
            case (bidx_ff)
               sbfp_pkg::SMP_HI:  emit_byte = mem_rd_data[23:16];
               sbfp_pkg::SMP_MID: emit_byte = mem_rd_data[15:8];
               sbfp_pkg::SMP_LO:  emit_byte = mem_rd_data[7:0];
               default:           emit_byte = mem_rd_data[7:0];
            endcase
         end
         sbfp_pkg::ST_SUM: begin
            emit_valid = 1'b1;
            emit_byte  = sum_ff;
         end
         sbfp_pkg::ST_END: begin
            emit_valid = 1'b1;
            emit_byte  = sbfp_pkg::END_BYTE;
            emit_last  = 1'b1;
         end
         default: begin
            emit_valid = 1'b0;
         end
      endcase
   end

   assign fire      = emit_valid && (!out_valid_ff || rsp_tready);
   assign mem_rd_en = (state_ff == sbfp_pkg::ST_FETCH);

   // Sequencer and buffer bookkeeping
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rp_in       = rp_ff;
      dropping_in = dropping_ff;
      n_in        = n_ff;
      sidx_in     = sidx_ff;
      bidx_in     = bidx_ff;
      addr_in     = addr_ff;
      sum_in      = sum_ff;
      case (state_ff)
         sbfp_pkg::ST_IDLE: begin
            if (accept && (cmd == sbfp_pkg::CMD_APPEND)) begin
               dropping_in = drop_now;
               if (keep) begin
                  count_in = count_ff + 1'b1;
               end
            end else if (accept) begin
               if (rp_ff >= count_ff) begin
                  count_in = '0;
                  rp_in    = '0;
               end else begin
                  if (CMPW'(remaining) > CMPW'(SAMPLES_PER_FRAME)) begin
                     n_in = NW'(SAMPLES_PER_FRAME);
                  end else begin
                     n_in = NW'(remaining);
                  end
                  sidx_in  = '0;
                  bidx_in  = sbfp_pkg::HDR_SYNC;
                  addr_in  = AW'(rp_ff);
                  sum_in   = '0;
                  state_in = sbfp_pkg::ST_HEAD;
               end
            end
         end
         sbfp_pkg::ST_HEAD: begin
            if (fire) begin
               if (bidx_ff == sbfp_pkg::HDR_COUNT) begin
                  state_in = sbfp_pkg::ST_FETCH;
               end else begin
                  bidx_in = bidx_ff + 1'b1;
               end
            end
         end
         sbfp_pkg::ST_FETCH: begin
            addr_in  = addr_ff + 1'b1;
            bidx_in  = sbfp_pkg::SMP_HI;
            state_in = sbfp_pkg::ST_DATA;
         end
         sbfp_pkg::ST_DATA: begin
            if (fire) begin
               if (bidx_ff == sbfp_pkg::SMP_LO) begin
                  sidx_in = sidx_ff + 1'b1;
                  if (NW'(sidx_ff + 1'b1) == n_ff) begin
                     state_in = sbfp_pkg::ST_SUM;
                  end else begin
                     state_in = sbfp_pkg::ST_FETCH;
                  end
               end else begin
                  bidx_in = bidx_ff + 1'b1;
               end
            end
         end
         sbfp_pkg::ST_SUM: begin
            if (fire) begin
               state_in = sbfp_pkg::ST_END;
            end
         end
         sbfp_pkg::ST_END: begin
            if (fire) begin
               if (rp_next >= count_ff) begin
                  count_in = '0;
                  rp_in    = '0;
               end else begin
                  rp_in = rp_next;
               end
               state_in = sbfp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbfp_pkg::ST_IDLE;
         end
      endcase
      // Accumulate the checksum through a byte adder
      if (fire && emit_sums) begin
         sum_in = sum_ff + emit_byte;
      end
   end

   // Output register: load on send, drop on take
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbfp_pkg::ST_IDLE;
         count_ff     <= '0;
         rp_ff        <= '0;
         dropping_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         dropping_ff  <= dropping_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      sidx_ff     <= sidx_in;
      bidx_ff     <= bidx_in;
      addr_ff     <= addr_in;
      sum_ff      <= sum_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   sbfp_sample_mem #(
      .DEPTH (MAX_SAMPLES),
      .WIDTH (sbfp_pkg::SAMPLE_W)
   ) u_sample_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (AW'(count_ff)),
      .wr_data (sample),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
